>>> rtl/swsu_pkg.sv
// Package: shared constants, types and sequence helpers of the sliding window sender.
`default_nettype none

package swsu_pkg;

    localparam int SEQ_COUNT = 8;
    localparam int SEQ_W     = 3;
    localparam int PAYLOAD_W = 32;
    localparam int CFG_W     = 3;
    localparam int DUP_W     = 2;
    localparam int TMR_W     = 2;
    localparam int CMD_W     = 2;

    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(4);
    localparam logic [DUP_W-1:0] DUP_LIMIT    = DUP_W'(3);

    localparam logic [CMD_W-1:0] CMD_SEND    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE    = 2'd3;

    localparam logic [TMR_W-1:0] TMR_NONE    = 2'd0;
    localparam logic [TMR_W-1:0] TMR_START   = 2'd1;
    localparam logic [TMR_W-1:0] TMR_STOP    = 2'd2;
    localparam logic [TMR_W-1:0] TMR_RESTART = 2'd3;

    typedef logic [SEQ_W-1:0] t_seq;

    typedef struct packed {
        logic                 accepted;
        logic                 tx_valid;
        t_seq                 tx_sequence;
        logic [PAYLOAD_W-1:0] tx_payload;
        logic [TMR_W-1:0]     timer_action;
        t_seq                 window_base;
        t_seq                 next_sequence;
    } t_result;

    // (a + b) mod SEQ_COUNT, both operands below SEQ_COUNT
    function automatic t_seq seq_add(input t_seq a, input t_seq b);
        logic [SEQ_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (SEQ_W+1)'(SEQ_COUNT)) begin
            sum = sum - (SEQ_W+1)'(SEQ_COUNT);
        end
        return sum[SEQ_W-1:0];
    endfunction

    function automatic t_seq seq_inc(input t_seq a);
        return (a == SEQ_W'(SEQ_COUNT - 1)) ? '0 : a + SEQ_W'(1);
    endfunction

endpackage

`default_nettype wire

>>> rtl/swsu_if.sv
// Interfaces: command, result and configuration channels.
`default_nettype none

interface swsu_cmd_if import swsu_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [PAYLOAD_W-1:0] payload;
    logic [SEQ_W-1:0]     ack_number;
    logic                 ack_ok;

    modport source (output valid, command, payload, ack_number, ack_ok, input ready);
    modport sink   (input valid, command, payload, ack_number, ack_ok, output ready);
endinterface

interface swsu_res_if import swsu_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 accepted;
    logic                 tx_valid;
    logic [SEQ_W-1:0]     tx_sequence;
    logic [PAYLOAD_W-1:0] tx_payload;
    logic [TMR_W-1:0]     timer_action;
    logic [SEQ_W-1:0]     window_base;
    logic [SEQ_W-1:0]     next_sequence;

    modport source (output valid, accepted, tx_valid, tx_sequence, tx_payload,
                    timer_action, window_base, next_sequence, input ready);
    modport sink   (input valid, accepted, tx_valid, tx_sequence, tx_payload,
                    timer_action, window_base, next_sequence, output ready);
endinterface

interface swsu_cfg_if import swsu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] window_size;

    modport source (output valid, window_size, input ready);
    modport sink   (input valid, window_size, output ready);
endinterface

`default_nettype wire

>>> rtl/sliding_window_sender_unit.sv
// Top level: sliding window sender with fast retransmit.
//
//  channel  dir  handshake        carries
//  i_cmd    in   valid / ready    command, payload, ack_number, ack_ok
//  o_res    out  valid / ready    accepted, tx_*, timer_action, window_base, next_sequence
//  i_cfg    in   valid / ready    window_size (ready whenever out of reset)
//
// One command per cycle while i_cmd.ready is high: state and the result are computed in
// the accept cycle; the result is registered in the output or, on a stall, skid register.
// The result path holds two entries (output and skid register); i_cmd.ready
// drops only when both are full, so a stall on o_res costs nothing until then.
// Synchronous active-low reset: base, next, duplicate count zero, window 4;
// the packet store is not cleared. Both input channels are not ready in reset.
`default_nettype none

module sliding_window_sender_unit import swsu_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    swsu_cmd_if.sink   i_cmd,
    swsu_cfg_if.sink   i_cfg,
    swsu_res_if.source o_res
);

    logic    cmd_fire;
    logic    buf_ready;
    t_result core_res;
    t_result out_res;

    assign i_cfg.ready = i_rst_n;
    assign i_cmd.ready = buf_ready && i_rst_n;
    assign cmd_fire    = i_cmd.valid && buf_ready;

    swsu_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (cmd_fire),
        .i_command    (i_cmd.command),
        .i_payload    (i_cmd.payload),
        .i_ack_number (i_cmd.ack_number),
        .i_ack_ok     (i_cmd.ack_ok),
        .i_cfg_fire   (i_cfg.valid),
        .i_cfg_window (i_cfg.window_size),
        .o_result     (core_res)
    );

    swsu_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd.valid),
        .i_data  (core_res),
        .o_ready (buf_ready),
        .o_valid (o_res.valid),
        .o_data  (out_res),
        .i_ready (o_res.ready)
    );

    assign o_res.accepted      = out_res.accepted;
    assign o_res.tx_valid      = out_res.tx_valid;
    assign o_res.tx_sequence   = out_res.tx_sequence;
    assign o_res.tx_payload    = out_res.tx_payload;
    assign o_res.timer_action  = out_res.timer_action;
    assign o_res.window_base   = out_res.window_base;
    assign o_res.next_sequence = out_res.next_sequence;

endmodule

`default_nettype wire

>>> rtl/swsu_core.sv
// Sender state: window pointers, duplicate ACK count, packet store and result logic.
`default_nettype none

module swsu_core import swsu_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire logic [CMD_W-1:0]     i_command,
    input  wire logic [PAYLOAD_W-1:0] i_payload,
    input  wire logic [SEQ_W-1:0]     i_ack_number,
    input  wire logic                 i_ack_ok,
    input  wire logic                 i_cfg_fire,
    input  wire logic [CFG_W-1:0]     i_cfg_window,
    output t_result                   o_result
);

    logic [CFG_W-1:0]     r_window;
    t_seq                 r_base, n_base;
    t_seq                 r_next, n_next;
    logic [DUP_W-1:0]     r_dup, n_dup;
    logic [PAYLOAD_W-1:0] r_store [SEQ_COUNT];

    t_seq    eff_win;
    t_seq    win_end;
    logic    full;
    logic    in_win;
    logic    store_wr;
    t_result res;

    always_comb begin
        if (int'(r_window) >= SEQ_COUNT - 1) begin
            eff_win = SEQ_W'(SEQ_COUNT - 1);
        end else begin
            eff_win = SEQ_W'(r_window);
        end
        win_end = seq_add(r_base, eff_win);
        full    = (win_end == r_next);
        // window may wrap past the top of the sequence space
        if (r_base < win_end) begin
            in_win = (i_ack_number >= r_base) && (i_ack_number < win_end);
        end else begin
            in_win = (i_ack_number >= r_base) || (i_ack_number < win_end);
        end
    end

    always_comb begin
        n_base   = r_base;
        n_next   = r_next;
        n_dup    = r_dup;
        store_wr = 1'b0;
        res      = '0;
        res.accepted = 1'b1;
        unique case (i_command)
            CMD_SEND: begin
                if (full) begin
                    res.accepted = 1'b0;
                end else begin
                    store_wr         = 1'b1;
                    res.tx_valid     = 1'b1;
                    res.tx_sequence  = r_next;
                    res.tx_payload   = i_payload;
                    res.timer_action = (r_base == r_next) ? TMR_START : TMR_NONE;
                    n_next           = seq_inc(r_next);
                end
            end
            CMD_ACK: begin
                if (i_ack_ok) begin
                    if (in_win) begin
                        n_base = seq_inc(i_ack_number);
                        res.timer_action = (n_base != r_next) ? TMR_RESTART : TMR_STOP;
                        n_dup  = '0;
                    end else if (r_dup == DUP_LIMIT) begin
                        // fast retransmit of the oldest packet
                        res.tx_valid    = 1'b1;
                        res.tx_sequence = r_base;
                        res.tx_payload  = r_store[r_base];
                        n_dup           = '0;
                    end else begin
                        n_dup = r_dup + DUP_W'(1);
                    end
                end
            end
            CMD_TIMEOUT: begin
                res.tx_valid     = 1'b1;
                res.tx_sequence  = r_base;
                res.tx_payload   = r_store[r_base];
                res.timer_action = TMR_RESTART;
            end
            CMD_NONE: begin
            end
        endcase
        res.window_base   = n_base;
        res.next_sequence = n_next;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
            r_base   <= '0;
            r_next   <= '0;
            r_dup    <= '0;
        end else begin
            if (i_cfg_fire) begin
                r_window <= i_cfg_window;
            end
            if (i_fire) begin
                r_base <= n_base;
                r_next <= n_next;
                r_dup  <= n_dup;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && store_wr) begin
            r_store[r_next] <= i_payload;
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !res.tx_valid |-> (res.tx_sequence == '0) && (res.tx_payload == '0))
        else $error("tx fields not cleared without transmission");

    a_full_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_command == CMD_SEND && full |=> $stable(r_next) && $stable(r_base))
        else $error("refused send moved the window");

    a_fast_rtx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_command == CMD_ACK && i_ack_ok && !in_win && r_dup == DUP_LIMIT
        |-> res.tx_valid && res.tx_sequence == r_base)
        else $error("fourth duplicate ACK did not resend the base packet");

    a_timeout_rtx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_command == CMD_TIMEOUT |-> res.tx_valid && res.timer_action == TMR_RESTART
        && res.window_base == r_base)
        else $error("timeout did not resend the base packet");
`endif

endmodule

`default_nettype wire

>>> rtl/swsu_out_buf.sv
// Result buffer: output register plus skid register so input ready is registered.
`default_nettype none

module swsu_out_buf import swsu_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_result i_data,
    output logic         o_ready,
    output logic         o_valid,
    output t_result      o_data,
    input  wire logic    i_ready
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    in_fire;
    logic    out_fire;

    assign o_ready  = !r_skid_valid;
    assign in_fire  = i_valid && !r_skid_valid;
    assign out_fire = r_out_valid && i_ready;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_fire) begin
            r_out_valid <= in_fire;
        end else if (in_fire) begin
            // output stalled: park the transaction
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || out_fire) begin
            if (in_fire) begin
                r_out <= i_data;
            end
        end else if (in_fire) begin
            r_skid <= i_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a transaction with the output empty");

    a_park: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready && !r_skid_valid && i_valid |=> r_skid_valid)
        else $error("transaction lost while output stalled");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !out_fire |=> r_skid_valid && $stable(r_skid))
        else $error("parked transaction dropped or changed");
`endif

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Testbench top: random and directed commands, results checked against a predictor.
module tb_top;
    import swsu_pkg::*;

    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 140;
    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int REPORT_MAX  = 10;

    // window per random phase; both extremes included
    localparam logic [PHASES-1:0][CFG_W-1:0] PHASE_WIN =
        {3'd1, 3'd7, 3'd4, 3'd6, 3'd2, 3'd5, 3'd3, 3'd0, 3'd1, 3'd7};

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic [PAYLOAD_W-1:0] payload;
        t_seq                 ack_number;
        logic                 ack_ok;
    } t_cmd_item;

    typedef struct packed {
        t_seq                                base;
        t_seq                                nxt;
        logic [DUP_W-1:0]                    dups;
        logic [CFG_W-1:0]                    win;
        logic [SEQ_COUNT-1:0]                filled;
        logic [SEQ_COUNT-1:0][PAYLOAD_W-1:0] store;
    } t_sender_state;

    logic i_clk = 1'b0;
    logic i_rst_n;

    swsu_cmd_if cmd_if ();
    swsu_res_if res_if ();
    swsu_cfg_if cfg_if ();

    sliding_window_sender_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    always #2 i_clk = ~i_clk;

    t_sender_state shadow_st;   // tracks accepted transactions
    t_sender_state plan_st;     // tracks queued stimulus
    t_cmd_item     cmd_backlog[$];
    t_result       due_results[$];

    int   n_planned     = 0;
    int   n_accepted    = 0;
    int   n_cfg         = 0;
    int   mismatches    = 0;
    int   stall_cycles  = 0;
    int   hold_requests = 0;
    int   holds_done    = 0;
    int   hold_left     = 0;
    int   send_gap      = 0;
    int   send_calm     = 0;
    int   recv_gap      = 0;
    int   recv_calm     = 0;
    logic cmd_taken     = 1'b0;
    logic res_taken     = 1'b0;

    function automatic t_seq seq_step(input t_seq a, input int k);
        return t_seq'((int'(a) + k) % SEQ_COUNT);
    endfunction

    function automatic t_seq window_stop(input t_sender_state s);
        int lim;
        lim = (int'(s.win) >= SEQ_COUNT - 1) ? SEQ_COUNT - 1 : int'(s.win);
        return seq_step(s.base, lim);
    endfunction

    function automatic logic ack_inside(input t_sender_state s, input t_seq ack);
        t_seq stop;
        stop = window_stop(s);
        if (s.base < stop) begin
            return (ack >= s.base) && (ack < stop);
        end
        return (ack >= s.base) || (ack < stop);
    endfunction

    function automatic t_result advance_sender(inout t_sender_state s, input t_cmd_item c);
        t_result r;
        r = '0;
        r.accepted = 1'b1;
        case (c.command)
            CMD_SEND: begin
                if (window_stop(s) == s.nxt) begin
                    r.accepted = 1'b0;
                end else begin
                    s.store[s.nxt]  = c.payload;
                    s.filled[s.nxt] = 1'b1;
                    if (s.base == s.nxt) begin
                        r.timer_action = TMR_START;
                    end
                    r.tx_valid    = 1'b1;
                    r.tx_sequence = s.nxt;
                    r.tx_payload  = c.payload;
                    s.nxt         = seq_step(s.nxt, 1);
                end
            end
            CMD_ACK: begin
                if (c.ack_ok) begin
                    if (ack_inside(s, c.ack_number)) begin
                        s.base         = seq_step(c.ack_number, 1);
                        r.timer_action = (s.base != s.nxt) ? TMR_RESTART : TMR_STOP;
                        s.dups         = '0;
                    end else if (s.dups == DUP_LIMIT) begin
                        // fast retransmit of the base packet
                        r.tx_valid    = 1'b1;
                        r.tx_sequence = s.base;
                        r.tx_payload  = s.store[s.base];
                        s.dups        = '0;
                    end else begin
                        s.dups = s.dups + 1'b1;
                    end
                end
            end
            CMD_TIMEOUT: begin
                r.tx_valid     = 1'b1;
                r.tx_sequence  = s.base;
                r.tx_payload   = s.store[s.base];
                r.timer_action = TMR_RESTART;
            end
            default: ;
        endcase
        r.window_base   = s.base;
        r.next_sequence = s.nxt;
        return r;
    endfunction

    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(16, 48);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    // Queue one command; never resend a store entry that was not written yet.
    task automatic plan_item(input logic [CMD_W-1:0] cmd, input logic [PAYLOAD_W-1:0] pay,
                             input t_seq ack, input logic ok);
        t_cmd_item c;
        t_result   unused;
        c = '{command: cmd, payload: pay, ack_number: ack, ack_ok: ok};
        if (c.command == CMD_TIMEOUT && !plan_st.filled[plan_st.base]) begin
            c.command = CMD_SEND;
        end
        if (c.command == CMD_ACK && c.ack_ok && !ack_inside(plan_st, c.ack_number) &&
            plan_st.dups == DUP_LIMIT && !plan_st.filled[plan_st.base]) begin
            c.ack_ok = 1'b0;
        end
        unused = advance_sender(plan_st, c);
        cmd_backlog.push_back(c);
        n_planned++;
    endtask

    task automatic plan_random(input int count);
        int               made;
        int               pick;
        int               span;
        logic [CMD_W-1:0] cmd;
        logic [31:0]      pay;
        t_seq             ack;
        logic             ok;
        made = 0;
        while (made < count) begin
            pay  = $urandom;
            ack  = t_seq'($urandom_range(0, SEQ_COUNT - 1));
            ok   = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                // run of duplicate ACKs just below the base
                repeat (4) plan_item(CMD_ACK, pay, seq_step(plan_st.base, SEQ_COUNT - 1), 1'b1);
                made += 4;
            end else begin
                if (pick < 45) begin
                    cmd = CMD_SEND;
                end else if (pick < 80) begin
                    cmd  = CMD_ACK;
                    ok   = ($urandom_range(0, 9) != 0);
                    span = (int'(plan_st.nxt) - int'(plan_st.base) + SEQ_COUNT) % SEQ_COUNT;
                    if (span != 0 && $urandom_range(0, 2) != 0) begin
                        ack = seq_step(plan_st.base, $urandom_range(0, span - 1));
                    end
                end else if (pick < 92) begin
                    cmd = CMD_TIMEOUT;
                end else begin
                    cmd = CMD_NONE;
                end
                plan_item(cmd, pay, ack, ok);
                made++;
            end
        end
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (cmd_backlog.size() != 0 || n_accepted != n_planned || due_results.size() != 0);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] w);
        int seen;
        seen = n_cfg;
        cfg_if.valid       <= 1'b1;
        cfg_if.window_size <= w;
        do @(negedge i_clk);
        while (n_cfg == seen);
        cfg_if.valid <= 1'b0;
        plan_st.win = w;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
                $display("%s mismatch: expected %0h, got %0h", name, want, got);
            end
        end
    endtask

    // Command driver: hold each transaction until taken, then wait its drawn gap.
    always @(negedge i_clk) begin : drive_cmd
        t_cmd_item c;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                cmd_if.valid <= 1'b0;
            end else if (cmd_backlog.size() != 0) begin
                c = cmd_backlog.pop_front();
                cmd_if.command    <= c.command;
                cmd_if.payload    <= c.payload;
                cmd_if.ack_number <= c.ack_number;
                cmd_if.ack_ok     <= c.ack_ok;
                cmd_if.valid      <= 1'b1;
                send_gap = draw_wait(send_calm);
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else if (holds_done != hold_requests) begin
            holds_done++;
            hold_left = LONG_HOLD - 1;
            res_if.ready <= 1'b0;
        end else begin
            if (res_taken) begin
                recv_gap = draw_wait(recv_calm);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Monitor: check results first, then predict for the command taken at this edge.
    always @(posedge i_clk) begin : watch_channels
        t_result   want;
        t_cmd_item seen;
        logic      moved;
        cmd_taken <= i_rst_n && cmd_if.valid && cmd_if.ready;
        res_taken <= i_rst_n && res_if.valid && res_if.ready;
        if (i_rst_n) begin
            moved = 1'b0;
            if (res_if.valid && res_if.ready) begin
                moved = 1'b1;
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("result transaction with nothing outstanding");
                    end
                end else begin
                    want = due_results.pop_front();
                    compare_field("accepted", want.accepted, res_if.accepted);
                    compare_field("tx_valid", want.tx_valid, res_if.tx_valid);
                    compare_field("tx_sequence", want.tx_sequence, res_if.tx_sequence);
                    compare_field("tx_payload", want.tx_payload, res_if.tx_payload);
                    compare_field("timer_action", want.timer_action, res_if.timer_action);
                    compare_field("window_base", want.window_base, res_if.window_base);
                    compare_field("next_sequence", want.next_sequence, res_if.next_sequence);
                end
            end
            if (cmd_if.valid && cmd_if.ready) begin
                moved = 1'b1;
                seen = '{command: cmd_if.command, payload: cmd_if.payload,
                         ack_number: cmd_if.ack_number, ack_ok: cmd_if.ack_ok};
                due_results.push_back(advance_sender(shadow_st, seen));
                n_accepted++;
            end
            if (cfg_if.valid && cfg_if.ready) begin
                moved = 1'b1;
                shadow_st.win = cfg_if.window_size;
                n_cfg++;
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        cmd_if.valid       = 1'b0;
        cmd_if.command     = CMD_NONE;
        cmd_if.payload     = '0;
        cmd_if.ack_number  = '0;
        cmd_if.ack_ok      = 1'b0;
        res_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.window_size = '0;
        shadow_st          = '0;
        shadow_st.win      = WINDOW_RESET;
        plan_st            = shadow_st;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: fill the reset window, refuse when full, drop, dup ACKs, resends
        plan_item(CMD_SEND, 32'h0000_0000, 3'd7, 1'b1);
        plan_item(CMD_SEND, 32'hFFFF_FFFF, 3'd0, 1'b0);
        plan_item(CMD_SEND, 32'hA5A5_5A5A, 3'd5, 1'b1);
        plan_item(CMD_SEND, 32'h0F0F_F0F0, 3'd2, 1'b0);
        plan_item(CMD_SEND, 32'h1234_5678, 3'd0, 1'b0);
        plan_item(CMD_ACK, 32'hFFFF_FFFF, 3'd7, 1'b0);
        repeat (4) plan_item(CMD_ACK, 32'h0, 3'd6, 1'b1);
        plan_item(CMD_TIMEOUT, 32'hDEAD_BEEF, 3'd1, 1'b1);
        plan_item(CMD_ACK, 32'h0, 3'd1, 1'b1);
        plan_item(CMD_NONE, 32'hFFFF_FFFF, 3'd7, 1'b1);
        plan_item(CMD_ACK, 32'h0, 3'd3, 1'b1);
        plan_item(CMD_TIMEOUT, 32'h0, 3'd0, 1'b0);
        plan_item(CMD_SEND, 32'h8000_0001, 3'd4, 1'b1);

        for (int i = 0; i < PHASES; i++) begin
            drain();
            write_window(PHASE_WIN[i]);
            @(posedge i_clk);
            if (i == 1 || i == 6) begin
                hold_requests++;
            end
            plan_random(PHASE_ITEMS);
        end

        drain();
        repeat (8) @(negedge i_clk);
        mismatches += due_results.size();
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/swsu_pkg.sv
rtl/swsu_if.sv
rtl/swsu_core.sv
rtl/swsu_out_buf.sv
rtl/sliding_window_sender_unit.sv
sim/tb_top.sv
